@@ sv/bpfa_pkg.sv @@
// Package with the types, constants and control words of the page frame allocator.
`default_nettype none
package bpfa_pkg;

  localparam int BITMAP_WORDS  = 1024;
  localparam int BITS_PER_WORD = 32;
  localparam int MAX_ALLOC_WORDS = 1024;
  localparam int SCAN_WORDS =
    (BITMAP_WORDS < MAX_ALLOC_WORDS) ? BITMAP_WORDS : MAX_ALLOC_WORDS;
  localparam int NUM_FRAMES = BITMAP_WORDS * BITS_PER_WORD;
  localparam int WORD_AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int BIT_AW  = $clog2(BITS_PER_WORD);
  localparam logic [31:0] FULL_WORD = 32'hFFFF_FFFF;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_TEST    = 2'd2;
  localparam logic [1:0] REQ_RESERVE = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NONE_FREE = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_NOT_USED  = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [14:0] frame_number;
  } bpfa_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] result_frame;
    logic        was_used;
  } bpfa_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;       // write zero at the sweep address and advance
    logic load;        // capture the request word and its word address
    logic next_word;   // advance the allocation scan
    logic commit;      // write back and emit the result
    logic emit_range;  // emit an out-of-range result for the input word
    logic emit_none;   // emit a no-free-frame result
  } bpfa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic range_bad;
    logic is_alloc;
    logic word_full;
    logic scan_last;
  } bpfa_sts_t;

endpackage
`default_nettype wire

@@ sv/bpfa_dp.sv @@
// Datapath of the page frame allocator: bitmap memory, request registers and result register.
`default_nettype none
module bpfa_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bpfa_pkg::bpfa_req_t in_req,
  input  wire bpfa_pkg::bpfa_cmd_t cmd,
  output bpfa_pkg::bpfa_sts_t     sts,
  output logic                    out_valid,
  output bpfa_pkg::bpfa_res_t     out_res
);
  import bpfa_pkg::*;

  logic [31:0]        mem [BITMAP_WORDS];
  logic [31:0]        rdata_r;
  logic [WORD_AW-1:0] addr_r, addr_nxt;
  logic [1:0]         req_r;
  logic [14:0]        frame_r;
  logic               valid_r, valid_nxt;
  bpfa_res_t          res_r, res_nxt;

  logic [WORD_AW-1:0] in_word;
  logic [BIT_AW-1:0]  free_bit;
  logic [31:0]        mask;
  logic               used;
  logic               wr_en;
  logic [31:0]        wdata;

  function automatic logic [BIT_AW-1:0] lowest_zero(input logic [31:0] v);
    logic [BIT_AW-1:0] b;
    b = '0;
    for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
      if (!v[i]) b = BIT_AW'(i);
    end
    return b;
  endfunction

  assign in_word  = WORD_AW'(32'(in_req.frame_number) >> BIT_AW);
  assign free_bit = lowest_zero(rdata_r);
  assign mask     = 32'(1) << frame_r[BIT_AW-1:0];
  assign used     = |(rdata_r & mask);

  assign sts.clear_last = (addr_r == WORD_AW'(BITMAP_WORDS - 1));
  assign sts.range_bad  = (32'(in_req.frame_number) >= 32'(NUM_FRAMES));
  assign sts.is_alloc   = (req_r == REQ_ALLOC);
  assign sts.word_full  = (rdata_r == FULL_WORD);
  assign sts.scan_last  = (addr_r == WORD_AW'(SCAN_WORDS - 1));

  always_comb begin
    addr_nxt  = addr_r;
    valid_nxt = 1'b0;
    res_nxt   = res_r;
    wr_en     = 1'b0;
    wdata     = rdata_r;
    if (cmd.clear || cmd.next_word) addr_nxt = addr_r + WORD_AW'(1);
    if (cmd.load) begin
      addr_nxt = (in_req.req_type == REQ_ALLOC) ? '0 : in_word;
    end
    if (cmd.emit_range) begin
      valid_nxt = 1'b1;
      res_nxt   = '{status: ST_RANGE, result_frame: in_req.frame_number, was_used: 1'b0};
    end
    if (cmd.emit_none) begin
      valid_nxt = 1'b1;
      res_nxt   = '{status: ST_NONE_FREE, result_frame: 15'd0, was_used: 1'b0};
    end
    if (cmd.commit) begin
      valid_nxt = 1'b1;
      case (req_r)
        REQ_ALLOC: begin
          wr_en   = 1'b1;
          wdata   = rdata_r | (32'(1) << free_bit);
          res_nxt = '{status: ST_OK,
                      result_frame: 15'((32'(addr_r) << BIT_AW) | 32'(free_bit)),
                      was_used: 1'b0};
        end
        REQ_FREE: begin
          wr_en   = used;
          wdata   = rdata_r & ~mask;
          res_nxt = '{status: used ? ST_OK : ST_NOT_USED, result_frame: frame_r,
                      was_used: used};
        end
        REQ_RESERVE: begin
          wr_en   = 1'b1;
          wdata   = rdata_r | mask;
          res_nxt = '{status: ST_OK, result_frame: frame_r, was_used: used};
        end
        default: begin
          res_nxt = '{status: ST_OK, result_frame: frame_r, was_used: used};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[addr_r] <= '0;
    end else if (wr_en) begin
      mem[addr_r] <= wdata;
    end
    rdata_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      addr_r  <= addr_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (cmd.load) begin
      req_r   <= in_req.req_type;
      frame_r <= in_req.frame_number;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

@@ sv/bpfa_ctrl.sv @@
// Controller state machine of the page frame allocator.
`default_nettype none
module bpfa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire bpfa_pkg::bpfa_sts_t sts,
  output bpfa_pkg::bpfa_cmd_t      cmd
);
  import bpfa_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_CHECK = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          // The range check needs no memory access, so it answers at once.
          if (sts.range_bad) begin
            cmd.emit_range = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.is_alloc && sts.word_full) begin
          if (sts.scan_last) begin
            cmd.emit_none = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cmd.next_word = 1'b1;
            state_nxt     = S_READ;
          end
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

@@ sv/bitmap_page_frame_allocator_unit.sv @@
// Bitmap page frame allocator: one result word for every request word.
// Free, test and reserve read their word and commit; allocate scans from word 0
// for the first non-full word, one word per read, or reports that none is free.
// Out-of-range free, test and reserve requests answer in the cycle after acceptance;
// the result strobe lasts one cycle and the receiver cannot stall it. After reset,
// busy stays high while the bitmap memory is cleared one word a cycle.
`default_nettype none
module bitmap_page_frame_allocator_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire bpfa_pkg::bpfa_req_t in_req,
  output logic                     out_valid,
  output bpfa_pkg::bpfa_res_t      out_res
);
  import bpfa_pkg::*;

  bpfa_cmd_t cmd;
  bpfa_sts_t sts;
  bpfa_sts_t sts_ctrl;

  // The controller's range decision only applies to non-allocate requests.
  always_comb begin
    sts_ctrl           = sts;
    sts_ctrl.range_bad = sts.range_bad && (in_req.req_type != REQ_ALLOC);
  end

  bpfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts_ctrl),
    .cmd   (cmd)
  );

  bpfa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule
`default_nettype wire
